/* rtl/dsv_pkg.sv */
package dsv_pkg;

  localparam int CHAR_W    = 8;
  localparam int DAY_W     = 7;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int STATUS_W  = 3;
  localparam int POS_W     = 4;
  localparam int CENTURY_W = 7;
  localparam int TEXT_W    = 24;
  localparam int DIM_W     = 5;
  localparam int NUM_MONTHS = 12;

  localparam logic [POS_W-1:0] POS_MAX     = 4'd15;
  localparam logic [POS_W-1:0] POS_LAST    = 4'd10;
  localparam logic [POS_W-1:0] POS_SLASH_A = 4'd2;
  localparam logic [POS_W-1:0] POS_SLASH_B = 4'd6;
  localparam logic [POS_W-1:0] POS_MONTH_A = 4'd3;
  localparam logic [POS_W-1:0] POS_MONTH_C = 4'd5;
  localparam logic [POS_W-1:0] POS_CENTURY = 4'd9;

  localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  localparam logic [YEAR_W-1:0] YEAR_MIN_RESET = 14'd2000;
  localparam logic [YEAR_W-1:0] YEAR_MAX_RESET = 14'd2099;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_YEAR_MIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_YEAR_MAX = 2'd1;

  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_LENGTH    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FORMAT    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_YEAR      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DAY_RANGE = 3'd4;

  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;

  // Month abbreviations, first letter in the high byte.
  localparam logic [TEXT_W-1:0] MONTH_NAMES [NUM_MONTHS] = '{
    24'h6A616E, 24'h666576, 24'h6D6172, 24'h616272, 24'h6D6169, 24'h6A756E,
    24'h6A756C, 24'h61676F, 24'h736574, 24'h6F7574, 24'h6E6F76, 24'h64657A
  };

  localparam logic [DIM_W-1:0] MONTH_DAYS [NUM_MONTHS] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Everything gathered from one text, as seen with its last character.
  typedef struct packed {
    logic                 len_ok;
    logic                 format_bad;
    logic [DAY_W-1:0]     day_value;
    logic [TEXT_W-1:0]    month_text;
    logic [YEAR_W-1:0]    year_value;
    logic [CENTURY_W-1:0] century_digits;
  } text_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month_index;
    logic [YEAR_W-1:0]   year;
  } result_t;

endpackage

/* rtl/date_string_validator_top.sv */
// Date text checker for dd/mmm/yyyy with Portuguese month abbreviations.
// Throughput: one character per cycle, with no idle cycles between texts, while the
// result register is free; the last character of a text waits for it. The result of a
// text goes into the result register as its last character leaves the input register.
// Reset clears the text state and both pipeline stages; year_min and year_max return to
// 2000 and 2099.
module date_string_validator_top
  import dsv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,  // [7:0] character
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [31:0]            m_axis_tdata,  // [2:0] status, [9:3] day,
                                                // [13:10] month_index, [27:14] year
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [YEAR_W-1:0]      cfg_data
);

  logic [YEAR_W-1:0] year_min;
  logic [YEAR_W-1:0] year_max;

  // Input stage
  logic              in_valid;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;
  logic              in_go;

  // Per-text state
  logic [POS_W-1:0]     position;
  logic                 format_bad;
  logic [DAY_W-1:0]     day_value;
  logic [TEXT_W-1:0]    month_text;
  logic [YEAR_W-1:0]    year_value;
  logic [CENTURY_W-1:0] century_digits;

  logic                 format_bad_next;
  logic [DAY_W-1:0]     day_value_next;
  logic [TEXT_W-1:0]    month_text_next;
  logic [YEAR_W-1:0]    year_value_next;
  logic [CENTURY_W-1:0] century_digits_next;

  logic                 is_digit;
  logic [3:0]           digit;
  text_t                text;
  result_t              result_next;

  // Result stage
  logic    out_valid;
  logic    out_free;
  result_t out_result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      year_min <= YEAR_MIN_RESET;
      year_max <= YEAR_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_YEAR_MIN: year_min <= cfg_data;
        REG_YEAR_MAX: year_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // A character other than the last never needs the result register.
  assign out_free      = !out_valid || m_axis_tready;
  assign in_go         = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || in_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  assign is_digit = (in_char >= CHAR_ZERO) && (in_char <= CHAR_NINE);
  assign digit    = is_digit ? in_char[3:0] : 4'd0;

  always_comb begin
    format_bad_next     = format_bad;
    day_value_next      = day_value;
    month_text_next     = month_text;
    year_value_next     = year_value;
    century_digits_next = century_digits;
    if (position <= POS_LAST) begin
      if (position == POS_SLASH_A || position == POS_SLASH_B) begin
        if (in_char != CHAR_SLASH) begin
          format_bad_next = 1'b1;
        end
      end else if (position >= POS_MONTH_A && position <= POS_MONTH_C) begin
        month_text_next = {month_text[TEXT_W-CHAR_W-1:0], in_char};
      end else begin
        if (!is_digit) begin
          format_bad_next = 1'b1;
        end
        if (position < POS_SLASH_A) begin
          day_value_next = {day_value[DAY_W-4:0], 3'b0} + {day_value[DAY_W-2:0], 1'b0}
                         + DAY_W'(digit);
        end else begin
          year_value_next = {year_value[YEAR_W-4:0], 3'b0} + {year_value[YEAR_W-2:0], 1'b0}
                          + YEAR_W'(digit);
          if (position < POS_CENTURY) begin
            century_digits_next = {century_digits[CENTURY_W-4:0], 3'b0}
                                + {century_digits[CENTURY_W-2:0], 1'b0}
                                + CENTURY_W'(digit);
          end
        end
      end
    end
  end

  assign text.len_ok         = (position == POS_LAST);
  assign text.format_bad     = format_bad_next;
  assign text.day_value      = day_value_next;
  assign text.month_text     = month_text_next;
  assign text.year_value     = year_value_next;
  assign text.century_digits = century_digits_next;

  dsv_judge u_judge (
    .text     (text),
    .year_min (year_min),
    .year_max (year_max),
    .result   (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst || (in_go && in_last)) begin
      position       <= '0;
      format_bad     <= 1'b0;
      day_value      <= '0;
      month_text     <= '0;
      year_value     <= '0;
      century_digits <= '0;
    end else if (in_go) begin
      if (position != POS_MAX) begin
        position <= position + POS_W'(1);
      end
      format_bad     <= format_bad_next;
      day_value      <= day_value_next;
      month_text     <= month_text_next;
      year_value     <= year_value_next;
      century_digits <= century_digits_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_go && in_last) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go && in_last) begin
      out_result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_result.year, out_result.month_index,
                          out_result.day, out_result.status};

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    in_go && in_last |=> position == '0 && !format_bad)
    else $error("text state not cleared after the last character");

  a_rejected_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.status == ST_LENGTH || out_result.status == ST_FORMAT)
    |-> out_result.day == '0 && out_result.month_index == '0 && out_result.year == '0)
    else $error("rejected text reports nonzero fields");

  a_ok_day_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_result.status == ST_OK
    |-> out_result.day != '0 && out_result.day <= DAY_W'(31)
        && out_result.month_index < MONTH_W'(NUM_MONTHS)
        && out_result.year >= year_min && out_result.year <= year_max)
    else $error("accepted date has fields out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(out_result))
    else $error("pending result overwritten");
`endif

endmodule

/* rtl/dsv_judge.sv */
module dsv_judge
  import dsv_pkg::*;
(
  input  text_t             text,
  input  logic [YEAR_W-1:0] year_min,
  input  logic [YEAR_W-1:0] year_max,
  output result_t           result
);

  logic                 found;
  logic [MONTH_W-1:0]   month_index;
  logic [YEAR_W-1:0]    century_x100;
  logic [YEAR_W-1:0]    low2;
  logic                 leap;
  logic [DIM_W-1:0]     dim;
  logic [STATUS_W-1:0]  status;

  // The names are all different, so at most one entry can match.
  always_comb begin
    found       = 1'b0;
    month_index = '0;
    for (int i = 0; i < NUM_MONTHS; i++) begin
      if (text.month_text == MONTH_NAMES[i]) begin
        found       = 1'b1;
        month_index = MONTH_W'(i);
      end
    end
  end

  // The last two year digits come from removing the century part.
  assign century_x100 = YEAR_W'({text.century_digits, 6'b0})
                      + YEAR_W'({text.century_digits, 5'b0})
                      + YEAR_W'({text.century_digits, 2'b0});
  assign low2 = text.year_value - century_x100;
  assign leap = (low2 != '0) ? (low2[1:0] == 2'b00) : (text.century_digits[1:0] == 2'b00);
  assign dim  = MONTH_DAYS[month_index] + DIM_W'(month_index == MONTH_FEB && leap);

  always_comb begin
    if (!text.len_ok) begin
      status = ST_LENGTH;
    end else if (text.format_bad || !found) begin
      status = ST_FORMAT;
    end else if (text.year_value < year_min || text.year_value > year_max) begin
      status = ST_YEAR;
    end else if (text.day_value == '0 || text.day_value > DAY_W'(dim)) begin
      status = ST_DAY_RANGE;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    result.status = status;
    if (status == ST_LENGTH || status == ST_FORMAT) begin
      result.day         = '0;
      result.month_index = '0;
      result.year        = '0;
    end else begin
      result.day         = text.day_value;
      result.month_index = month_index;
      result.year        = text.year_value;
    end
  end

endmodule

/* test/date_check.sv */
`timescale 1ns / 1ps

module date_check
  import dsv_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [31:0]            m_axis_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [YEAR_W-1:0]      cfg_data,
  output int                     mismatches,
  output int                     outstanding
);

  logic [YEAR_W-1:0]    year_lo;
  logic [YEAR_W-1:0]    year_hi;
  logic [POS_W-1:0]     pos;
  logic                 bad_seen;
  logic [DAY_W-1:0]     day_acc;
  logic [TEXT_W-1:0]    month_acc;
  logic [YEAR_W-1:0]    year_acc;
  logic [CENTURY_W-1:0] century_acc;
  result_t              expected_dates[$];
  result_t              want;
  int                   fails = 0;

  task automatic clear_text();
    pos         = '0;
    bad_seen    = 1'b0;
    day_acc     = '0;
    month_acc   = '0;
    year_acc    = '0;
    century_acc = '0;
  endtask

  function automatic result_t judge_date(input logic len_ok);
    logic               found;
    logic [MONTH_W-1:0] mi;
    logic [31:0]        low2;
    logic               leap;
    int                 dim;
    int                 i;
    result_t            r;
    found = 1'b0;
    mi    = '0;
    for (i = 0; i < NUM_MONTHS; i++) begin
      if (!found && month_acc == MONTH_NAMES[i]) begin
        found = 1'b1;
        mi    = MONTH_W'(i);
      end
    end
    r = '0;
    if (!len_ok) begin
      r.status = ST_LENGTH;
    end else if (bad_seen || !found) begin
      r.status = ST_FORMAT;
    end else if (year_acc < year_lo || year_acc > year_hi) begin
      r.status = ST_YEAR;
    end else begin
      // A year ending in 00 is a leap year only when its century is a multiple of four.
      low2 = 32'(year_acc) - 32'(century_acc) * 32'd100;
      leap = (low2 != 0) ? (low2[1:0] == 2'b00) : (century_acc[1:0] == 2'b00);
      dim  = int'(MONTH_DAYS[mi]) + ((mi == MONTH_FEB && leap) ? 1 : 0);
      r.status = (day_acc < 1 || day_acc > dim) ? ST_DAY_RANGE : ST_OK;
    end
    if (r.status != ST_LENGTH && r.status != ST_FORMAT) begin
      r.day         = day_acc;
      r.month_index = mi;
      r.year        = year_acc;
    end
    return r;
  endfunction

  task automatic take_character(input logic [CHAR_W-1:0] c, input logic last);
    logic digit;
    int   d;
    logic len_ok;
    digit  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    d      = digit ? int'(c - CHAR_ZERO) : 0;
    len_ok = (pos == POS_LAST);
    if (pos <= POS_LAST) begin
      if (pos == POS_SLASH_A || pos == POS_SLASH_B) begin
        if (c != CHAR_SLASH) bad_seen = 1'b1;
      end else if (pos >= POS_MONTH_A && pos <= POS_MONTH_C) begin
        month_acc = {month_acc[TEXT_W-CHAR_W-1:0], c};
      end else begin
        if (!digit) bad_seen = 1'b1;
        if (pos < POS_SLASH_A) begin
          day_acc = DAY_W'(day_acc * 10 + d);
        end else begin
          year_acc = YEAR_W'(year_acc * 10 + d);
          if (pos < POS_CENTURY) century_acc = CENTURY_W'(century_acc * 10 + d);
        end
      end
    end
    if (pos != POS_MAX) pos = pos + 1'b1;
    if (last) begin
      expected_dates.push_back(judge_date(len_ok));
      clear_text();
    end
  endtask

  task automatic check_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s expected %0d actual %0d", $time, field, exp_val, act_val);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      year_lo = YEAR_MIN_RESET;
      year_hi = YEAR_MAX_RESET;
      clear_text();
      expected_dates.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_YEAR_MIN: year_lo = cfg_data;
          REG_YEAR_MAX: year_hi = cfg_data;
          default: ;
        endcase
      end
      // The result of a new request is never due on the same edge, so compare first.
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: result with no date pending, expected none actual tdata %h",
                   $time, m_axis_tdata);
          fails++;
        end else begin
          want = expected_dates.pop_front();
          check_field("status", want.status, m_axis_tdata[2:0]);
          check_field("day", want.day, m_axis_tdata[9:3]);
          check_field("month_index", want.month_index, m_axis_tdata[13:10]);
          check_field("year", want.year, m_axis_tdata[27:14]);
        end
      end
      if (s_axis_tvalid && s_axis_tready) take_character(s_axis_tdata, s_axis_tlast);
    end
    outstanding <= expected_dates.size();
    mismatches  <= fails;
  end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import dsv_pkg::*;

  typedef logic [CHAR_W-1:0] char_t;
  typedef char_t text_q[$];
  typedef enum {RX_OPEN, RX_CHOPPY, RX_HOLD} rx_mode_t;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;  // [7:0] character
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [31:0]            m_axis_tdata;        // [2:0] status, [9:3] day,
                                               // [13:10] month_index, [27:14] year
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index     = '0;
  logic [YEAR_W-1:0]      cfg_data      = '0;
  int                     mismatches;
  int                     outstanding;

  int       burst_left = 0;
  int       sent_chars = 0;
  int       cur_min    = 2000;
  int       cur_max    = 2099;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_left    = 0;

  date_string_validator_top DUT (.*);
  date_check u_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The result side switches between open, choppy and fully stalled stretches.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 12) : $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_CHOPPY: m_axis_tready <= ($urandom_range(0, 2) != 0);
      default:   m_axis_tready <= 1'b0;
    endcase
  end

  task automatic send_char(input char_t c, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sent_chars++;
  endtask

  task automatic send_text(input text_q t);
    int i;
    for (i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  // Waits until every pending date has come back.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [YEAR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_years(input int lo, input int hi);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_YEAR_MIN, YEAR_W'(lo));
    write_reg(REG_YEAR_MAX, YEAR_W'(hi));
    cfg_valid <= 1'b0;
    cur_min = lo;
    cur_max = hi;
  endtask

  function automatic text_q from_string(input string s);
    text_q t;
    int    i;
    for (i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic text_q make_date(input int day, input int mi, input int year);
    text_q t;
    t.push_back(char_t'(CHAR_ZERO + day / 10));
    t.push_back(char_t'(CHAR_ZERO + day % 10));
    t.push_back(CHAR_SLASH);
    t.push_back(MONTH_NAMES[mi][23:16]);
    t.push_back(MONTH_NAMES[mi][15:8]);
    t.push_back(MONTH_NAMES[mi][7:0]);
    t.push_back(CHAR_SLASH);
    t.push_back(char_t'(CHAR_ZERO + year / 1000));
    t.push_back(char_t'(CHAR_ZERO + (year / 100) % 10));
    t.push_back(char_t'(CHAR_ZERO + (year / 10) % 10));
    t.push_back(char_t'(CHAR_ZERO + year % 10));
    return t;
  endfunction

  function automatic text_q random_text();
    text_q t;
    int    kind;
    int    pick;
    int    year;
    int    day;
    int    n;
    int    top;
    kind = $urandom_range(0, 99);
    if (kind >= 88) begin
      n = ($urandom_range(0, 3) == 0) ? 11 : $urandom_range(1, 20);
      repeat (n) t.push_back(char_t'($urandom_range(0, 255)));
      return t;
    end
    pick = $urandom_range(0, 9);
    top  = (cur_max > 9999) ? 9999 : cur_max;
    if (pick <= 5 && cur_min <= top) begin
      year = $urandom_range(cur_min, top);
    end else if (pick == 6) begin
      case ($urandom_range(0, 6))
        0: year = 1900;
        1: year = 2000;
        2: year = 2100;
        3: year = 2400;
        4: year = 1600;
        5: year = 0;
        default: year = 9999;
      endcase
    end else if (pick == 7) begin
      year = ($urandom_range(0, 1) != 0) ? cur_min - 1 : cur_max + 1;
      if (year < 0 || year > 9999) year = $urandom_range(0, 9999);
    end else begin
      year = $urandom_range(0, 9999);
    end
    pick = $urandom_range(0, 3);
    day  = (pick <= 1) ? $urandom_range(1, 28) :
           (pick == 2) ? $urandom_range(28, 32) : $urandom_range(0, 99);
    t = make_date(day, $urandom_range(0, NUM_MONTHS - 1), year);
    if (kind >= 80) begin
      if ($urandom_range(0, 1) != 0) begin
        repeat ($urandom_range(1, 10)) void'(t.pop_back());
      end else begin
        repeat ($urandom_range(1, 9)) t.push_back(char_t'($urandom_range(0, 255)));
      end
    end else if (kind >= 70) begin
      t[$urandom_range(0, 10)] = char_t'($urandom_range(0, 255));
    end
    return t;
  endfunction

  string reset_range_dates[] = '{
    "29/fev/2024", "29/fev/2023", "00/jan/2050", "31/dez/2099", "01/jan/2000",
    "15/mar/1999", "15/mar/2100", "31/abr/2010", "99/ago/2010", "1x/mai/2010",
    "12-jun/2010", "12/jul-2010", "12/Jul/2010", "12/set/20a0", "7",
    "12/out/201", "12/nov/20100", "12/nov/2010/////////"
  };
  string wide_range_dates[] = '{
    "29/fev/1900", "29/fev/2000", "29/fev/0000", "28/fev/1900", "09/set/9999",
    "31/nov/0004"
  };

  initial begin
    text_q filler;
    int    phase;
    int    phase_start;
    int    lo;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (reset_range_dates[i]) send_text(from_string(reset_range_dates[i]));
    repeat (11) filler.push_back(8'hFF);
    send_text(filler);
    filler.delete();
    repeat (11) filler.push_back(8'h00);
    send_text(filler);

    set_years(0, 16383);
    foreach (wide_range_dates[i]) send_text(from_string(wide_range_dates[i]));
    set_years(9999, 0);
    send_text(from_string("01/jan/2000"));

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          lo = $urandom_range(0, 9999);
          set_years(lo, lo + $urandom_range(0, 400));
        end
        1: set_years(0, 9999);
        2: set_years($urandom_range(0, 16383), $urandom_range(0, 16383));
        default: set_years(YEAR_MIN_RESET, YEAR_MAX_RESET);
      endcase
      phase_start = sent_chars;
      while (sent_chars - phase_start < 375) begin
        send_text(random_text());
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
